@@ rtl/core/pab_pkg.sv @@
// Shared constants and types for the premultiplied alpha blend pipeline.
package pab_pkg;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned PROD_W   = 16;
	localparam int unsigned NUM_W    = 25;
	localparam int unsigned QEST_W   = 9;
	localparam int unsigned RECIP_W  = 17;
	localparam int unsigned RPROD_W  = NUM_W + RECIP_W;
	localparam int unsigned RSHIFT   = 32;
	localparam int unsigned N_COLOR  = 3;

	localparam logic [CH_W-1:0]    FULL_SCALE = 8'd255;
	localparam logic [PROD_W-1:0]  FULL_SQ    = 16'd65025;
	localparam logic [NUM_W-1:0]   HALF_SQ    = 25'd32512;
	// floor(2^32 / 65025); quotient estimate is low by at most one
	localparam logic [RECIP_W-1:0] RECIP_SQ   = 17'd66051;

	localparam logic [CH_W-1:0]    ALPHA_RESET = 8'd255;

	typedef struct packed {
		logic s3;
		logic s4;
	} pab_en_t;

endpackage

@@ rtl/core/pab_round_div.sv @@
// Two-stage divide by 65025 with saturation at 255 (numerator already holds the rounding bias).
module pab_round_div (
	input  logic                          clk,
	input  pab_pkg::pab_en_t              en,
	input  logic [pab_pkg::NUM_W-1:0]     num,
	output logic [pab_pkg::CH_W-1:0]      res
);
	import pab_pkg::*;

	logic [RPROD_W-1:0] rprod;
	logic [NUM_W-1:0]   num_s3;
	logic [QEST_W-1:0]  qest_s3;
	logic [NUM_W-1:0]   qmul;
	logic [NUM_W-1:0]   rem;
	logic [QEST_W:0]    qfix;
	logic [CH_W-1:0]    res_s4;

	assign rprod = RPROD_W'(num) * RPROD_W'(RECIP_SQ);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			num_s3  <= num;
			qest_s3 <= rprod[RSHIFT+QEST_W-1:RSHIFT];
		end
	end

	// one correction step: estimate is q or q-1
	assign qmul = NUM_W'(qest_s3) * NUM_W'(FULL_SQ);
	assign rem  = num_s3 - qmul;

	always_comb begin
		qfix = {1'b0, qest_s3};
		if (rem >= NUM_W'(FULL_SQ)) begin
			qfix = qfix + (QEST_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			if (qfix > (QEST_W+1)'(FULL_SCALE)) begin
				res_s4 <= FULL_SCALE;
			end else begin
				res_s4 <= qfix[CH_W-1:0];
			end
		end
	end

	assign res = res_s4;

endmodule

@@ rtl/core/premultiplied_alpha_blend.sv @@
// Top level: Porter-Duff over of a premultiplied ARGB source onto a destination pixel.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  cfg     | cfg_valid / cfg_ready  | const_alpha (global opacity k/255)
//  in      | in_valid  / in_ready   | src_alpha/red/green/blue, dst_alpha/red/green/blue
//  out     | out_valid / out_ready  | out_alpha/red/green/blue
//
// Four register stages, one pixel per clock sustained while out_ready stays high.
// Stage 1 forms sa*k and c*k, stage 2 the numerators over 65025, stage 3
// the reciprocal quotient estimate, stage 4 the correction and saturation.
// Each stage holds when the next is full and stalled; bubbles collapse.
// Reset clears the valid bits and sets const_alpha to 255.
// cfg_ready is always high; a write takes effect on the next request.
module premultiplied_alpha_blend (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [pab_pkg::CH_W-1:0]   const_alpha,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pab_pkg::CH_W-1:0]   src_alpha,
	input  logic [pab_pkg::CH_W-1:0]   src_red,
	input  logic [pab_pkg::CH_W-1:0]   src_green,
	input  logic [pab_pkg::CH_W-1:0]   src_blue,
	input  logic [pab_pkg::CH_W-1:0]   dst_alpha,
	input  logic [pab_pkg::CH_W-1:0]   dst_red,
	input  logic [pab_pkg::CH_W-1:0]   dst_green,
	input  logic [pab_pkg::CH_W-1:0]   dst_blue,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pab_pkg::CH_W-1:0]   out_alpha,
	output logic [pab_pkg::CH_W-1:0]   out_red,
	output logic [pab_pkg::CH_W-1:0]   out_green,
	output logic [pab_pkg::CH_W-1:0]   out_blue
);
	import pab_pkg::*;

	logic [CH_W-1:0] k_q;

	// valid bits per stage
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	pab_en_t en;

	// stage 1 payload
	logic [PROD_W-1:0] sak_s1;
	logic [CH_W-1:0]   da_s1;
	logic [PROD_W-1:0] ck_s1 [N_COLOR];
	logic [CH_W-1:0]   d_s1  [N_COLOR];

	// stage 2 payload: biased numerators, alpha then colors
	logic [NUM_W-1:0]  num_s2 [N_COLOR+1];

	logic [CH_W-1:0]   src_c [N_COLOR];
	logic [CH_W-1:0]   dst_c [N_COLOR];
	logic [NUM_W-1:0]  num_nx [N_COLOR+1];
	logic [CH_W-1:0]   res    [N_COLOR+1];

	assign src_c[0] = src_red;
	assign src_c[1] = src_green;
	assign src_c[2] = src_blue;
	assign dst_c[0] = dst_red;
	assign dst_c[1] = dst_green;
	assign dst_c[2] = dst_blue;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			k_q <= const_alpha;
		end
	end

	// backpressure chain: a stage can load when empty or when it drains
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign en.s3 = rdy_s3 && v_s2;
	assign en.s4 = rdy_s4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage 1: scale source by k
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			sak_s1 <= PROD_W'(src_alpha) * PROD_W'(k_q);
			da_s1  <= dst_alpha;
			for (int i = 0; i < N_COLOR; i++) begin
				ck_s1[i] <= PROD_W'(src_c[i]) * PROD_W'(k_q);
				d_s1[i]  <= dst_c[i];
			end
		end
	end

	// stage 2: numerators over 65025 plus half for round-half-up
	always_comb begin
		num_nx[0] = NUM_W'(sak_s1) * NUM_W'(FULL_SCALE - da_s1)
			+ NUM_W'(da_s1) * NUM_W'(FULL_SQ) + HALF_SQ;
		for (int i = 0; i < N_COLOR; i++) begin
			num_nx[i+1] = NUM_W'(FULL_SQ - sak_s1) * NUM_W'(d_s1[i])
				+ ((NUM_W'(ck_s1[i]) << CH_W) - NUM_W'(ck_s1[i])) + HALF_SQ;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			for (int i = 0; i <= N_COLOR; i++) begin
				num_s2[i] <= num_nx[i];
			end
		end
	end

	// stages 3 and 4: divide, correct, saturate
	for (genvar g = 0; g <= N_COLOR; g++) begin : g_div
		pab_round_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s2[g]),
			.res (res[g])
		);
	end

	assign out_valid = v_s4;
	assign out_alpha = res[0];
	assign out_red   = res[1];
	assign out_green = res[2];
	assign out_blue  = res[3];

endmodule
